### hdl/dlru_pkg.sv
// ----------------------------------------------------------------------------
// dlru_pkg
// Shared opcodes, field widths and control types of the clean-first LRU
// replacement block.
// ----------------------------------------------------------------------------
package dlru_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned SetW   = 6;
  localparam int unsigned WayW   = 3;
  localparam int unsigned DirtyW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned InW    = OpW + SetW + WayW + DirtyW + TimeW;
  localparam int unsigned InTdW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutW   = WayW + 1;
  localparam int unsigned OutTdW = ((OutW + 7) / 8) * 8;
  localparam int unsigned MaxWays = 32;
  localparam int unsigned MaxWayW = 5;

  typedef enum logic [OpW-1:0] {
    OP_INVALIDATE = 2'd0,
    OP_TOUCH      = 2'd1,
    OP_INSERT     = 2'd2,
    OP_VICTIM     = 2'd3
  } dlru_op_e;

  typedef struct packed {
    logic vld;
    logic first;
  } dlru_cmp_ctrl_t;

endpackage

### hdl/dirty_aware_lru_replacement.sv
// ----------------------------------------------------------------------------
// dirty_aware_lru_replacement
// Clean-first LRU replacement policy with a per-way timestamp store.
// ----------------------------------------------------------------------------
// One word at a time. After reset the stamp store is swept to zero, all
// SETS*WAYS words, with s_axis_tready low. set_index is folded into range
// by repeated subtraction of SETS, with none when SETS >= 64. Invalidate,
// touch and insert then pass through the update state and give no result.
// A victim query reads the set's stamps one way a cycle through the single
// RAM read port into one shared compare unit; the result is registered
// after the reduce, scan, drain and finish states. The input side reopens
// while a result waits on m_axis.
module dirty_aware_lru_replacement #(
  parameter int unsigned WAYS       = 8,
  parameter int unsigned SETS       = 64,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // opcode, set_index, way_index, dirty_mask, current_time (low to high)
  input  logic [dlru_pkg::InTdW-1:0]        s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // victim_way, victim_clean (low to high)
  output logic [dlru_pkg::OutTdW-1:0]       m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready
);

  localparam int unsigned DEPTH = SETS * WAYS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned WW    = $clog2(WAYS);
  localparam int unsigned KEY_W = STAMP_BITS + 1;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_REDUCE = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_SCAN   = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [AW-1:0]                   clr_cnt_q, clr_cnt_d;
  dlru_pkg::dlru_op_e              op_q, op_d;
  logic [dlru_pkg::SetW-1:0]       set_q, set_d;
  logic [dlru_pkg::WayW-1:0]       way_q, way_d;
  logic [dlru_pkg::DirtyW-1:0]     dirty_q, dirty_d;
  logic [dlru_pkg::TimeW-1:0]      time_q, time_d;
  logic [AW-1:0]                   base_q, base_d;
  logic [WW-1:0]                   rd_way_q, rd_way_d;
  logic                            cmp_vld_q, cmp_vld_d;
  logic [WW-1:0]                   cmp_way_q;
  logic                            out_vld_q, out_vld_d;
  logic [dlru_pkg::WayW-1:0]       out_way_q, out_way_d;
  logic                            out_clean_q, out_clean_d;

  logic                            mem_we, mem_re;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [STAMP_BITS-1:0]           mem_wdata, mem_rdata;

  logic                            in_acc;
  logic [dlru_pkg::MaxWays-1:0]    dirty_wide;
  logic [KEY_W-1:0]                cmp_key, best_key;
  logic [WW-1:0]                   best_way;
  dlru_pkg::dlru_cmp_ctrl_t        cmp_ctrl;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    op_d        = op_q;
    set_d       = set_q;
    way_d       = way_q;
    dirty_d     = dirty_q;
    time_d      = time_q;
    base_d      = base_q;
    rd_way_d    = rd_way_q;
    cmp_vld_d   = 1'b0;
    out_vld_d   = out_vld_q;
    out_way_d   = out_way_q;
    out_clean_d = out_clean_q;
    mem_we      = 1'b0;
    mem_waddr   = base_q + AW'(way_q);
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = base_q + AW'(rd_way_q);

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (32'(clr_cnt_q) == DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          op_d    = dlru_pkg::dlru_op_e'(s_axis_tdata[1:0]);
          set_d   = s_axis_tdata[7:2];
          way_d   = s_axis_tdata[10:8];
          dirty_d = s_axis_tdata[18:11];
          time_d  = s_axis_tdata[50:19];
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (32'(set_q) >= SETS) begin
          set_d = set_q - dlru_pkg::SetW'(SETS);
        end else begin
          base_d   = AW'(32'(set_q) * WAYS);
          rd_way_d = '0;
          state_d  = (op_q == dlru_pkg::OP_VICTIM) ? ST_SCAN : ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we    = (32'(way_q) < WAYS);
        mem_wdata = (op_q == dlru_pkg::OP_INVALIDATE) ? '0 : STAMP_BITS'(time_q);
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        cmp_vld_d = 1'b1;
        rd_way_d  = rd_way_q + 1'b1;
        if (32'(rd_way_q) == WAYS - 1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d   = 1'b1;
          out_way_d   = dlru_pkg::WayW'(best_way);
          out_clean_d = ~best_key[KEY_W-1];
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      cmp_vld_q <= cmp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    set_q       <= set_d;
    way_q       <= way_d;
    dirty_q     <= dirty_d;
    time_q      <= time_d;
    base_q      <= base_d;
    rd_way_q    <= rd_way_d;
    cmp_way_q   <= rd_way_q;
    out_way_q   <= out_way_d;
    out_clean_q <= out_clean_d;
  end

  assign dirty_wide     = dlru_pkg::MaxWays'(dirty_q);
  assign cmp_key        = {dirty_wide[dlru_pkg::MaxWayW'(cmp_way_q)], mem_rdata};
  assign cmp_ctrl.vld   = cmp_vld_q;
  assign cmp_ctrl.first = (cmp_way_q == '0);

  dlru_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  dlru_min_unit #(
    .KEY_W (KEY_W),
    .IDX_W (WW)
  ) u_min (
    .clk_i      (clk_i),
    .ctrl_i     (cmp_ctrl),
    .key_i      (cmp_key),
    .idx_i      (cmp_way_q),
    .best_key_o (best_key),
    .best_idx_o (best_way)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = dlru_pkg::OutTdW'({out_clean_q, out_way_q});

endmodule

### hdl/dlru_ram.sv
// ----------------------------------------------------------------------------
// dlru_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlru_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/dlru_min_unit.sv
// ----------------------------------------------------------------------------
// dlru_min_unit
// Shared compare unit: keeps the smallest key seen in a scan and its index,
// lowest index winning on ties.
// ----------------------------------------------------------------------------
module dlru_min_unit #(
  parameter int unsigned KEY_W = 33,
  parameter int unsigned IDX_W = 3
) (
  input  logic                    clk_i,
  input  dlru_pkg::dlru_cmp_ctrl_t ctrl_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [IDX_W-1:0]        idx_i,
  output logic [KEY_W-1:0]        best_key_o,
  output logic [IDX_W-1:0]        best_idx_o
);

  logic [KEY_W-1:0] best_key_q, best_key_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;

  always_comb begin
    best_key_d = best_key_q;
    best_idx_d = best_idx_q;
    if (ctrl_i.vld && (ctrl_i.first || (key_i < best_key_q))) begin
      best_key_d = key_i;
      best_idx_d = idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    best_key_q <= best_key_d;
    best_idx_q <= best_idx_d;
  end

  assign best_key_o = best_key_q;
  assign best_idx_o = best_idx_q;

endmodule

### hdl/dlru_checker.sv
// ----------------------------------------------------------------------------
// dlru_checker
// Port-level checks of the replacement block: results only answer queries,
// results hold while stalled, result fields stay in range.
// ----------------------------------------------------------------------------
module dlru_checker #(
  parameter int unsigned WAYS = 8
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic [dlru_pkg::InTdW-1:0]  s_axis_tdata,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic [dlru_pkg::OutTdW-1:0] m_axis_tdata,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready
);

  logic [1:0] pend_q, pend_d;
  logic       q_acc, r_acc;

  assign q_acc = s_axis_tvalid && s_axis_tready &&
                 (s_axis_tdata[1:0] == dlru_pkg::OP_VICTIM);
  assign r_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pend_d = pend_q + {1'b0, q_acc} - {1'b0, r_acc};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_result_needs_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pend_q != 2'd0))
    else $error("result without an outstanding victim query");

  a_pending_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two victim queries outstanding");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed or dropped");

  a_fields_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[7:4] == 4'd0) &&
                       ((WAYS > 8) || ({29'd0, m_axis_tdata[2:0]} < WAYS))))
    else $error("result word out of range");

endmodule

bind dirty_aware_lru_replacement dlru_checker #(.WAYS(WAYS)) u_dlru_checker (.*);

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the clean-first LRU replacement block against its own stamp-store
// predictor. Runs directed corner cases, random traffic under three idle
// mixes, a long result hold-off that fills the block, and drain pauses.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned NumWays = 8;
  localparam int unsigned NumSets = 64;

  typedef struct {
    dlru_pkg::dlru_op_e          opcode;
    logic [dlru_pkg::SetW-1:0]   set_index;
    logic [dlru_pkg::WayW-1:0]   way_index;
    logic [dlru_pkg::DirtyW-1:0] dirty_mask;
    logic [dlru_pkg::TimeW-1:0]  current_time;
  } lru_req_t;

  typedef struct {
    logic [dlru_pkg::WayW-1:0] victim_way;
    logic                      victim_clean;
  } victim_t;

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic [dlru_pkg::InTdW-1:0]  s_axis_tdata  = '0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [dlru_pkg::OutTdW-1:0] m_axis_tdata;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;

  logic [dlru_pkg::TimeW-1:0] model_stamps [NumSets*NumWays] = '{default: '0};
  victim_t                    pending_victims [$];
  logic [dlru_pkg::TimeW-1:0] clock_now      = '0;
  int                         mismatch_count = 0;
  int unsigned                send_idle_pct  = 0;
  int unsigned                recv_idle_pct  = 0;
  int unsigned                hold_left      = 0;

  dirty_aware_lru_replacement u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic lru_req_t mk_req(dlru_pkg::dlru_op_e op, int unsigned set,
                                      int unsigned way,
                                      logic [dlru_pkg::DirtyW-1:0] dirty,
                                      logic [dlru_pkg::TimeW-1:0] stamp);
    lru_req_t r;
    r.opcode       = op;
    r.set_index    = dlru_pkg::SetW'(set);
    r.way_index    = dlru_pkg::WayW'(way);
    r.dirty_mask   = dirty;
    r.current_time = stamp;
    return r;
  endfunction

  function automatic void predict_request(lru_req_t r);
    int unsigned                base;
    int unsigned                best_way;
    logic [dlru_pkg::TimeW-1:0] best_stamp;
    bit                         found;
    victim_t                    v;
    base       = (r.set_index % NumSets) * NumWays;
    best_way   = 0;
    best_stamp = '0;
    found      = 1'b0;
    case (r.opcode)
      dlru_pkg::OP_INVALIDATE: begin
        if (r.way_index < NumWays) model_stamps[base + r.way_index] = '0;
      end
      dlru_pkg::OP_TOUCH, dlru_pkg::OP_INSERT: begin
        if (r.way_index < NumWays) model_stamps[base + r.way_index] = r.current_time;
      end
      default: begin
        for (int unsigned w = 0; w < NumWays; w++) begin
          if (!r.dirty_mask[w] && (!found || model_stamps[base + w] < best_stamp)) begin
            found      = 1'b1;
            best_way   = w;
            best_stamp = model_stamps[base + w];
          end
        end
        if (!found) begin
          best_stamp = model_stamps[base];
          for (int unsigned w = 1; w < NumWays; w++) begin
            if (model_stamps[base + w] < best_stamp) begin
              best_way   = w;
              best_stamp = model_stamps[base + w];
            end
          end
        end
        v.victim_way   = dlru_pkg::WayW'(best_way);
        v.victim_clean = found;
        pending_victims.push_back(v);
      end
    endcase
  endfunction

  function automatic lru_req_t random_req();
    lru_req_t    r;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 30)      r.opcode = dlru_pkg::OP_VICTIM;
    else if (pick < 60) r.opcode = dlru_pkg::OP_TOUCH;
    else if (pick < 80) r.opcode = dlru_pkg::OP_INSERT;
    else                r.opcode = dlru_pkg::OP_INVALIDATE;
    r.set_index = ($urandom_range(3, 0) != 0) ? dlru_pkg::SetW'($urandom_range(3, 0)) :
                                                dlru_pkg::SetW'($urandom);
    r.way_index = dlru_pkg::WayW'($urandom);
    case ($urandom_range(9, 0))
      0:       r.dirty_mask = '0;
      1:       r.dirty_mask = '1;
      2:       r.dirty_mask = ~(dlru_pkg::DirtyW'(1) << $urandom_range(7, 0));
      default: r.dirty_mask = dlru_pkg::DirtyW'($urandom);
    endcase
    clock_now += $urandom_range(5, 1);
    case ($urandom_range(19, 0))
      0:       r.current_time = $urandom;
      1:       r.current_time = '1;
      2:       r.current_time = $urandom_range(3, 0);
      default: r.current_time = clock_now;
    endcase
    return r;
  endfunction

  task automatic send_word(input lru_req_t r);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(dlru_pkg::InTdW-dlru_pkg::InW){1'b0}}, r.current_time,
                      r.dirty_mask, r.way_index, r.set_index, r.opcode};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_request(r);
  endtask

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    victim_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_victims.size() == 0) begin
        report_mismatch("victim_way with nothing pending",
                        m_axis_tdata[dlru_pkg::WayW-1:0], 0);
      end else begin
        want = pending_victims.pop_front();
        if (m_axis_tdata[dlru_pkg::WayW-1:0] !== want.victim_way)
          report_mismatch("victim_way", m_axis_tdata[dlru_pkg::WayW-1:0],
                          want.victim_way);
        if (m_axis_tdata[dlru_pkg::WayW] !== want.victim_clean)
          report_mismatch("victim_clean", m_axis_tdata[dlru_pkg::WayW],
                          want.victim_clean);
      end
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(mk_req(dlru_pkg::OP_VICTIM, 0, 0, 8'h00, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 63, 7, 8'hFF, '1));
    send_word(mk_req(dlru_pkg::OP_TOUCH, 63, 0, 8'h00, 32'hFFFF_FFFF));
    send_word(mk_req(dlru_pkg::OP_INSERT, 63, 7, 8'hFF, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 63, 0, 8'h00, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 63, 0, 8'hFE, '0));
    for (int unsigned w = 0; w < NumWays; w++)
      send_word(mk_req(w[0] ? dlru_pkg::OP_TOUCH : dlru_pkg::OP_INSERT, 5, w, 8'h00,
                       1000 - 10 * w));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'h00, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'h80, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'hFF, '0));
    send_word(mk_req(dlru_pkg::OP_INVALIDATE, 5, 2, 8'h00, '1));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'h00, '0));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'h04, '0));
    send_word(mk_req(dlru_pkg::OP_TOUCH, 5, 2, 8'h00, 32'hFFFF_FFFF));
    send_word(mk_req(dlru_pkg::OP_VICTIM, 5, 0, 8'hFF, '0));
  endtask

  task automatic test_random(input int unsigned count, input int unsigned send_pct,
                             input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_word(random_req());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 400;
    repeat (60) send_word(random_req());
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 0;
    recv_idle_pct = 30;
    repeat (4) begin
      repeat (10) send_word(random_req());
      s_axis_tvalid <= 1'b0;
      wait (pending_victims.size() == 0);
      @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(350, 17, 77);
    test_random(350, 77, 17);
    test_random(350, 0, 0);
    test_backpressure();
    test_drain_pause();
    s_axis_tvalid <= 1'b0;
    wait (pending_victims.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
